FILE: rtl/pfd_pkg.sv
// Shared types, constants and helper functions for the Playfair digram decipher.
package pfd_pkg;

	localparam int unsigned SIDE    = 5;
	localparam int unsigned CELLS   = 25;
	localparam int unsigned LETTERS = 26;

	typedef logic [4:0] letter_t;
	typedef logic [4:0] pos_t;
	typedef logic [2:0] coord_t;

	localparam letter_t EMPTY_CODE = 5'd31;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_DECIPHER = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t opcode;
		pos_t    key_position;
		letter_t key_letter;
		letter_t first_letter;
		letter_t second_letter;
		logic    last_pair;
	} digram_t;

	typedef struct packed {
		letter_t plain_first;
		letter_t plain_second;
		logic    letter_missing;
		logic    last_pair_out;
	} plain_t;

	function automatic pos_t cell_index(coord_t row, coord_t col);
		pos_t r;
		r = {2'b00, row};
		return (r << 2) + r + {2'b00, col};
	endfunction

	function automatic coord_t row_of(pos_t p);
		coord_t r;
		if (p >= 5'd20) begin
			r = 3'd4;
		end else if (p >= 5'd15) begin
			r = 3'd3;
		end else if (p >= 5'd10) begin
			r = 3'd2;
		end else if (p >= 5'd5) begin
			r = 3'd1;
		end else begin
			r = 3'd0;
		end
		return r;
	endfunction

	function automatic coord_t col_of(pos_t p);
		pos_t d;
		d = p - cell_index(row_of(p), 3'd0);
		return d[2:0];
	endfunction

	function automatic coord_t wrap_back(coord_t v);
		return (v == 3'd0) ? coord_t'(SIDE - 1) : v - 3'd1;
	endfunction

	// lowest set position of a match vector
	function automatic pos_t first_index(logic [CELLS-1:0] m);
		pos_t p;
		p = '0;
		for (int i = CELLS - 1; i >= 0; i--) begin
			if (m[i]) begin
				p = pos_t'(i);
			end
		end
		return p;
	endfunction

endpackage

FILE: rtl/pfd_stream_if.sv
// Valid/ready stream channel carrying one item of a given payload type.
interface pfd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/playfair_digram_decipher.sv
// Playfair digram decipher: five-stage pipeline against a loadable 5x5 key square.
//
// Items on the digram channel either load one key square letter (opcode load) or decipher
// one digram (opcode decipher). The block takes one item every cycle unless the result
// channel stalls, and a decipher item's result leaves in order; load items give no result.
// Stage 1 registers the item, stage 2 holds the match vectors of both letters against the
// whole square, stage 3 the answer positions after the row, column or rectangle rule, stage
// 4 the two letters read from the square copies, stage 5 the result. A load takes effect
// for every item accepted after it. The square comes out of reset empty (every entry 31);
// a letter absent from the square gives zeros with letter_missing set. Backpressure on the
// result channel stalls the stages behind it without losing or repeating items.
module playfair_digram_decipher (
	input  logic         clk,
	input  logic         arst_n,
	pfd_stream_if.sink   digram,
	pfd_stream_if.source result
);
	localparam int unsigned CELLS = pfd_pkg::CELLS;

	logic en1, en2, en3, en4, en5;

	logic              v_s1;
	pfd_pkg::digram_t  item_s1;

	pfd_pkg::letter_t  key_q [CELLS];
	logic [CELLS-1:0]  match_a, match_b;
	logic              cam_we;

	logic              v_s2;
	pfd_pkg::opcode_t  op_s2;
	pfd_pkg::pos_t     pos_s2;
	pfd_pkg::letter_t  letter_s2;
	logic              last_s2;
	logic [CELLS-1:0]  match_a_s2, match_b_s2;

	pfd_pkg::pos_t     pa, pb, idx_f, idx_s;
	pfd_pkg::coord_t   ar, ac, br, bc;
	logic              miss;

	logic              v_s3;
	pfd_pkg::opcode_t  op_s3;
	pfd_pkg::pos_t     pos_s3;
	pfd_pkg::letter_t  letter_s3;
	logic              last_s3;
	logic              miss_s3;
	pfd_pkg::pos_t     idx_f_s3, idx_s_s3;

	logic              ram_we, ram_re;
	logic [CELLS-1:0]  vld_q;

	logic              v_s4;
	logic              miss_s4;
	logic              last_s4;
	logic              vld_f_s4, vld_s_s4;
	pfd_pkg::letter_t  rdata_f_s4, rdata_s_s4;

	logic              v_s5;
	pfd_pkg::plain_t   out_s5;

	assign en5 = !v_s5 || result.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign digram.ready = en1;
	assign result.valid = v_s5;
	assign result.data  = out_s5;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= digram.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1 <= digram.data;
		end
	end

	// search the square; write loads in item order
	assign cam_we = v_s1 && en2 && (item_s1.opcode == pfd_pkg::OP_LOAD)
		&& (item_s1.key_position < pfd_pkg::pos_t'(CELLS));

	always_comb begin
		for (int i = 0; i < CELLS; i++) begin
			match_a[i] = (key_q[i] == item_s1.first_letter)
				&& (item_s1.first_letter < pfd_pkg::letter_t'(pfd_pkg::LETTERS));
			match_b[i] = (key_q[i] == item_s1.second_letter)
				&& (item_s1.second_letter < pfd_pkg::letter_t'(pfd_pkg::LETTERS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				key_q[i] <= pfd_pkg::EMPTY_CODE;
			end
		end else if (cam_we) begin
			key_q[item_s1.key_position] <= item_s1.key_letter;
		end
	end

	// stage 2: match vectors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2      <= item_s1.opcode;
			pos_s2     <= item_s1.key_position;
			letter_s2  <= item_s1.key_letter;
			last_s2    <= item_s1.last_pair;
			match_a_s2 <= match_a;
			match_b_s2 <= match_b;
		end
	end

	always_comb begin
		pa   = pfd_pkg::first_index(match_a_s2);
		pb   = pfd_pkg::first_index(match_b_s2);
		miss = !(|match_a_s2) || !(|match_b_s2);
		ar   = pfd_pkg::row_of(pa);
		ac   = pfd_pkg::col_of(pa);
		br   = pfd_pkg::row_of(pb);
		bc   = pfd_pkg::col_of(pb);
		if (ar == br) begin
			idx_f = pfd_pkg::cell_index(ar, pfd_pkg::wrap_back(ac));
			idx_s = pfd_pkg::cell_index(br, pfd_pkg::wrap_back(bc));
		end else if (ac == bc) begin
			idx_f = pfd_pkg::cell_index(pfd_pkg::wrap_back(ar), ac);
			idx_s = pfd_pkg::cell_index(pfd_pkg::wrap_back(br), bc);
		end else begin
			idx_f = pfd_pkg::cell_index(ar, bc);
			idx_s = pfd_pkg::cell_index(br, ac);
		end
	end

	// stage 3: answer positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3     <= op_s2;
			pos_s3    <= pos_s2;
			letter_s3 <= letter_s2;
			last_s3   <= last_s2;
			miss_s3   <= miss;
			idx_f_s3  <= idx_f;
			idx_s_s3  <= idx_s;
		end
	end

	assign ram_we = v_s3 && en4 && (op_s3 == pfd_pkg::OP_LOAD)
		&& (pos_s3 < pfd_pkg::pos_t'(CELLS));
	assign ram_re = v_s3 && en4 && (op_s3 == pfd_pkg::OP_DECIPHER);

	pfd_ram #(
		.WIDTH ($bits(pfd_pkg::letter_t)),
		.DEPTH (CELLS)
	) u_ram_f (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_s3),
		.wdata (letter_s3),
		.re    (ram_re),
		.raddr (idx_f_s3),
		.rdata (rdata_f_s4)
	);

	pfd_ram #(
		.WIDTH ($bits(pfd_pkg::letter_t)),
		.DEPTH (CELLS)
	) u_ram_s (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_s3),
		.wdata (letter_s3),
		.re    (ram_re),
		.raddr (idx_s_s3),
		.rdata (rdata_s_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[pos_s3] <= 1'b1;
		end
	end

	// stage 4: square letters; drop load items here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3 && (op_s3 == pfd_pkg::OP_DECIPHER);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			miss_s4  <= miss_s3;
			last_s4  <= last_s3;
			vld_f_s4 <= vld_q[idx_f_s3];
			vld_s_s4 <= vld_q[idx_s_s3];
		end
	end

	// stage 5: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			out_s5.plain_first    <= miss_s4 ? '0
				: (vld_f_s4 ? rdata_f_s4 : pfd_pkg::EMPTY_CODE);
			out_s5.plain_second   <= miss_s4 ? '0
				: (vld_s_s4 ? rdata_s_s4 : pfd_pkg::EMPTY_CODE);
			out_s5.letter_missing <= miss_s4;
			out_s5.last_pair_out  <= last_s4;
		end
	end
endmodule

FILE: rtl/pfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfd_ram #(
	parameter int unsigned WIDTH = 5,
	parameter int unsigned DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: tb/playfair_digram_decipher_test.sv
// Self-checking testbench for the Playfair digram decipher: directed digrams, random keyed messages.
module playfair_digram_decipher_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_TARGET = 650;
	localparam int TAIL_CYCLES   = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfd_stream_if #(.payload_t(pfd_pkg::digram_t)) digram_ch ();
	pfd_stream_if #(.payload_t(pfd_pkg::plain_t))  result_ch ();

	playfair_digram_decipher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.digram (digram_ch),
		.result (result_ch)
	);

	pfd_pkg::letter_t square_copy[pfd_pkg::CELLS];
	pfd_pkg::plain_t  pending_plain[$];
	bit      steady_flow = 1'b0;
	int      errors = 0;
	int      cycles = 0;
	int      items_sent = 0;
	int      n_loads = 0;
	int      n_checked = 0;
	int      n_rows = 0;
	int      n_cols = 0;
	int      n_rects = 0;
	int      n_missing = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_plain.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic int locate_letter(pfd_pkg::letter_t l);
		if (l >= pfd_pkg::LETTERS) return -1;
		for (int i = 0; i < pfd_pkg::CELLS; i++) begin
			if (square_copy[i] == l) return i;
		end
		return -1;
	endfunction

	function automatic int step_back(int v);
		return (v == 0) ? int'(pfd_pkg::SIDE) - 1 : v - 1;
	endfunction

	function automatic pfd_pkg::plain_t decipher_digram(pfd_pkg::digram_t d);
		pfd_pkg::plain_t p;
		int pa, pb, ar, ac, br, bc;
		int side;
		side = int'(pfd_pkg::SIDE);
		p = '0;
		p.last_pair_out = d.last_pair;
		pa = locate_letter(d.first_letter);
		pb = locate_letter(d.second_letter);
		if (pa < 0 || pb < 0) begin
			p.letter_missing = 1'b1;
			n_missing++;
			return p;
		end
		ar = pa / side;
		ac = pa % side;
		br = pb / side;
		bc = pb % side;
		if (ar == br) begin
			p.plain_first  = square_copy[ar * side + step_back(ac)];
			p.plain_second = square_copy[br * side + step_back(bc)];
			n_rows++;
		end else if (ac == bc) begin
			p.plain_first  = square_copy[step_back(ar) * side + ac];
			p.plain_second = square_copy[step_back(br) * side + bc];
			n_cols++;
		end else begin
			p.plain_first  = square_copy[ar * side + bc];
			p.plain_second = square_copy[br * side + ac];
			n_rects++;
		end
		return p;
	endfunction

	task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
		errors++;
		$display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		pfd_pkg::plain_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_plain.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %p", $time, result_ch.data);
			end else begin
				want = pending_plain.pop_front();
				n_checked++;
				if (result_ch.data.plain_first !== want.plain_first)
					flag_field("plain_first", want.plain_first, result_ch.data.plain_first);
				if (result_ch.data.plain_second !== want.plain_second)
					flag_field("plain_second", want.plain_second, result_ch.data.plain_second);
				if (result_ch.data.letter_missing !== want.letter_missing)
					flag_field("letter_missing", want.letter_missing,
						result_ch.data.letter_missing);
				if (result_ch.data.last_pair_out !== want.last_pair_out)
					flag_field("last_pair_out", want.last_pair_out, result_ch.data.last_pair_out);
			end
		end
		result_ch.ready <= steady_flow || ($urandom_range(99) >= 30);
	end

	task automatic push_digram(input pfd_pkg::digram_t d);
		while (!steady_flow && $urandom_range(99) < 30) begin
			digram_ch.valid <= 1'b0;
			@(posedge clk);
		end
		digram_ch.valid <= 1'b1;
		digram_ch.data  <= d;
		@(posedge clk);
		while (!digram_ch.ready) @(posedge clk);
		items_sent++;
		if (d.opcode == pfd_pkg::OP_LOAD) begin
			n_loads++;
			if (d.key_position < pfd_pkg::CELLS) begin
				square_copy[d.key_position] = d.key_letter;
			end
		end else begin
			pending_plain.push_back(decipher_digram(d));
		end
	endtask

	task automatic load_cell(input pfd_pkg::pos_t pos, input pfd_pkg::letter_t l);
		pfd_pkg::digram_t d;
		d = pfd_pkg::digram_t'($urandom);
		d.opcode       = pfd_pkg::OP_LOAD;
		d.key_position = pos;
		d.key_letter   = l;
		push_digram(d);
	endtask

	task automatic decipher_pair(input pfd_pkg::letter_t a, input pfd_pkg::letter_t b,
		input logic last);
		pfd_pkg::digram_t d;
		d = pfd_pkg::digram_t'($urandom);
		d.opcode        = pfd_pkg::OP_DECIPHER;
		d.first_letter  = a;
		d.second_letter = b;
		d.last_pair     = last;
		push_digram(d);
	endtask

	task automatic hold_until_drained();
		digram_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_plain.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_square();
		decipher_pair(5'd0, 5'd0, 1'b0);
		decipher_pair(5'd25, 5'd31, 1'b1);
		decipher_pair(5'd26, 5'd12, 1'b0);
	endtask

	// alphabet without J, row by row
	task automatic test_cipher_rules();
		for (int p = 0; p < pfd_pkg::CELLS; p++) begin
			load_cell(pfd_pkg::pos_t'(p), pfd_pkg::letter_t'(p < 9 ? p : p + 1));
		end
		decipher_pair(5'd0, 5'd2, 1'b0);
		decipher_pair(5'd0, 5'd4, 1'b0);
		decipher_pair(5'd25, 5'd21, 1'b0);
		decipher_pair(5'd0, 5'd21, 1'b0);
		decipher_pair(5'd0, 5'd5, 1'b1);
		decipher_pair(5'd1, 5'd25, 1'b0);
		decipher_pair(5'd12, 5'd12, 1'b0);
		decipher_pair(5'd9, 5'd4, 1'b1);
		decipher_pair(5'd4, 5'd26, 1'b0);
		decipher_pair(5'd31, 5'd31, 1'b1);
	endtask

	task automatic test_odd_square_entries();
		load_cell(pfd_pkg::pos_t'(4), pfd_pkg::EMPTY_CODE);
		load_cell(pfd_pkg::pos_t'(24), 5'd26);
		load_cell(pfd_pkg::pos_t'(25), 5'd0);
		load_cell(pfd_pkg::pos_t'(31), 5'd7);
		load_cell(pfd_pkg::pos_t'(23), 5'd0);
		decipher_pair(5'd0, 5'd1, 1'b0);
		decipher_pair(5'd24, 5'd20, 1'b0);
		decipher_pair(5'd0, 5'd23, 1'b0);
		decipher_pair(5'd0, 5'd11, 1'b1);
	endtask

	task automatic test_random_messages();
		pfd_pkg::letter_t pick[pfd_pkg::LETTERS];
		int order[pfd_pkg::CELLS];
		pfd_pkg::letter_t a, b, t;
		int j, tmp, n, pa, pb, round;
		int side, cells;
		side  = int'(pfd_pkg::SIDE);
		cells = int'(pfd_pkg::CELLS);
		round = 0;
		while (items_sent < RANDOM_TARGET) begin
			steady_flow = (round == 3);
			for (int i = 0; i < pfd_pkg::LETTERS; i++) pick[i] = pfd_pkg::letter_t'(i);
			for (int i = pfd_pkg::LETTERS - 1; i > 0; i--) begin
				j = $urandom_range(i);
				t = pick[i];
				pick[i] = pick[j];
				pick[j] = t;
			end
			for (int i = 0; i < cells; i++) order[i] = i;
			for (int i = cells - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			for (int i = 0; i < cells; i++) begin
				load_cell(pfd_pkg::pos_t'(order[i]), pick[order[i]]);
				if ($urandom_range(19) == 0)
					load_cell(pfd_pkg::pos_t'($urandom_range(31, cells)),
						pfd_pkg::letter_t'($urandom_range(31)));
			end
			if ($urandom_range(3) == 0)
				load_cell(pfd_pkg::pos_t'($urandom_range(cells - 1)),
					pfd_pkg::letter_t'($urandom_range(31)));
			n = $urandom_range(50, 30);
			for (int k = 0; k < n; k++) begin
				pa = $urandom_range(cells - 1);
				case ($urandom_range(3))
					0: begin
						pb = (pa / side) * side + $urandom_range(side - 1);
					end
					1: begin
						pb = pa % side + side * $urandom_range(side - 1);
					end
					default: begin
						pb = $urandom_range(cells - 1);
					end
				endcase
				a = square_copy[pa];
				b = square_copy[pb];
				if ($urandom_range(11) == 0) a = pfd_pkg::letter_t'($urandom_range(31));
				if ($urandom_range(11) == 0) b = pfd_pkg::letter_t'($urandom_range(31));
				decipher_pair(a, b, (k == n - 1) || ($urandom_range(15) == 0));
			end
			if (round == 1) hold_until_drained();
			round++;
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		digram_ch.valid = 1'b0;
		digram_ch.data  = '0;
		for (int i = 0; i < pfd_pkg::CELLS; i++) square_copy[i] = pfd_pkg::EMPTY_CODE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_square();
		test_cipher_rules();
		test_odd_square_entries();
		test_random_messages();
		digram_ch.valid <= 1'b0;
		while (pending_plain.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items (%0d loads), %0d results checked, %0d errors", items_sent,
			n_loads, n_checked, errors);
		$display("digrams by rule: %0d same row, %0d same column, %0d rectangle, %0d missing",
			n_rows, n_cols, n_rects, n_missing);
		if (errors == 0 && pending_plain.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
